[rtl/tqls_pkg.sv]
// Shared widths, codes and types for the textured quad line splitter.
`default_nettype none

package tqls_pkg;

  localparam int COORD_BITS  = 24;
  localparam int KIND_BITS   = 3;
  localparam int NUM_COORDS  = 8;
  localparam int TDATA_BITS  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
  localparam int DIV_STEP    = 4;
  localparam int DIV_STAGES  = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_e;

  typedef enum logic [0:0] {
    CFG_SPLIT_AXIS = 1'b0,
    CFG_SPLIT_POS  = 1'b1
  } cfg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] ucoord_t;

  typedef struct packed {
    coord_t                left;
    coord_t                top;
    coord_t                right;
    coord_t                bottom;
    coord_t                tex_left;
    coord_t                tex_top;
    coord_t                tex_right;
    coord_t                tex_bottom;
    logic [KIND_BITS-1:0]  kind;
  } quad_t;

  typedef struct packed {
    logic   split;
    coord_t tex_line;
    quad_t  quad;
  } interp_t;

endpackage

`default_nettype wire

[rtl/tqls_interp.sv]
// Pipelined split test and texture interpolation at the split line.
`default_nettype none

module tqls_interp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tqls_pkg::axis_e  axis_i,
  input  tqls_pkg::coord_t pos_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tqls_pkg::quad_t  in_quad_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tqls_pkg::interp_t out_res_o
);
  import tqls_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int NS = PIPE_STAGES;
  localparam int DS = DIV_STAGES;

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  quad_t   quad_q  [NS];
  logic    split_q [NS];
  ucoord_t d_q     [NS-1];
  logic    neg_q   [NS-1];

  ucoord_t a_q, t_q;
  logic [2*CW-1:0] prod_q;

  logic [CW:0] rem_q [DS];
  ucoord_t     low_q [DS];
  ucoord_t     quo_q [DS];

  coord_t tl_q;

  // stage A: pick edges, test split, form differences
  coord_t n_a, f_a, tn_a, tf_a;
  logic   split_a, neg_a;
  logic signed [CW:0] a_w, d_w, t_w;

  always_comb begin
    if (axis_i == AXIS_Y) begin
      n_a  = in_quad_i.top;
      f_a  = in_quad_i.bottom;
      tn_a = in_quad_i.tex_top;
      tf_a = in_quad_i.tex_bottom;
    end else begin
      n_a  = in_quad_i.left;
      f_a  = in_quad_i.right;
      tn_a = in_quad_i.tex_left;
      tf_a = in_quad_i.tex_right;
    end
    split_a = (n_a < pos_i) && (pos_i < f_a);
    neg_a   = tf_a < tn_a;
    a_w     = {pos_i[CW-1], pos_i} - {n_a[CW-1], n_a};
    d_w     = {f_a[CW-1], f_a} - {n_a[CW-1], n_a};
    if (neg_a) begin
      t_w = {tn_a[CW-1], tn_a} - {tf_a[CW-1], tf_a};
    end else begin
      t_w = {tf_a[CW-1], tf_a} - {tn_a[CW-1], tn_a};
    end
  end

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      quad_q[0]  <= in_quad_i;
      split_q[0] <= split_a;
      d_q[0]     <= d_w[CW-1:0];
      neg_q[0]   <= neg_a;
      a_q        <= a_w[CW-1:0];
      t_q        <= t_w[CW-1:0];
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        quad_q[i]  <= quad_q[i-1];
        split_q[i] <= split_q[i-1];
      end
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (rdy[i]) begin
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  // stage B: product of texture span and distance to the line
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      prod_q <= t_q * a_q;
    end
  end

  // restoring division, DIV_STEP quotient bits per stage
  for (genvar s = 0; s < DS; s++) begin : g_div
    logic [CW:0] rem_in, rem_c;
    ucoord_t     low_in, low_c, quo_in, quo_c, d_in;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, prod_q[2*CW-1:CW]};
      assign low_in = prod_q[CW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end
    assign d_in = d_q[s+1];

    always_comb begin
      rem_c = rem_in;
      low_c = low_in;
      quo_c = quo_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        if (s * DIV_STEP + k < CW) begin
          rem_c = {rem_c[CW-1:0], low_c[CW-1]};
          low_c = {low_c[CW-2:0], 1'b0};
          quo_c = {quo_c[CW-2:0], 1'b0};
          if (rem_c >= {1'b0, d_in}) begin
            rem_c    = rem_c - {1'b0, d_in};
            quo_c[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s+2]) begin
        rem_q[s] <= rem_c;
        low_q[s] <= low_c;
        quo_q[s] <= quo_c;
      end
    end
  end

  // last stage: round half away from the near texture value, apply sign
  logic        half_r, neg_r;
  logic [CW:0] mag_r;
  logic [CW+1:0] tn_r, tl_w;
  ucoord_t     d_r;
  coord_t      tn_c;

  always_comb begin
    d_r    = d_q[NS-2];
    neg_r  = neg_q[NS-2];
    half_r = {rem_q[DS-1][CW-1:0], 1'b0} >= {1'b0, d_r};
    mag_r  = {1'b0, quo_q[DS-1]} + {{CW{1'b0}}, half_r};
    tn_c   = (axis_i == AXIS_Y) ? quad_q[NS-2].tex_top : quad_q[NS-2].tex_left;
    tn_r   = {{2{tn_c[CW-1]}}, tn_c};
    if (neg_r) begin
      tl_w = tn_r - {1'b0, mag_r};
    end else begin
      tl_w = tn_r + {1'b0, mag_r};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      tl_q <= tl_w[CW-1:0];
    end
  end

  assign out_valid_o        = v_q[NS-1];
  assign out_res_o.split    = split_q[NS-1];
  assign out_res_o.tex_line = tl_q;
  assign out_res_o.quad     = quad_q[NS-1];

endmodule

`default_nettype wire

[rtl/textured_quad_line_split.sv]
// Top level: splits axis-aligned textured quads at a configured line.
// The first piece leaves the piece stage, which follows the interpolation pipeline.
// Throughput: one quad per cycle when passed whole and m_axis_tready is high; a
// split quad holds the input until both pieces leave the single result port.
// Reset: asynchronous, active low; clears the pipeline and sets the split
// line to the vertical line at zero.
`default_nettype none

module textured_quad_line_split (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_index_i,
  input  logic [tqls_pkg::COORD_BITS-1:0]      cfg_wdata_i,
  // input quads
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pos_left, pos_top, pos_right, pos_bottom,
  // tex_left, tex_top, tex_right, tex_bottom
  input  logic [tqls_pkg::TDATA_BITS-1:0]      s_axis_tdata,
  // quad_kind
  input  logic [tqls_pkg::KIND_BITS-1:0]       s_axis_tuser,
  // output pieces
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_left, out_top, out_right, out_bottom,
  // out_tex_left, out_tex_top, out_tex_right, out_tex_bottom
  output logic [tqls_pkg::TDATA_BITS-1:0]      m_axis_tdata,
  // out_kind
  output logic [tqls_pkg::KIND_BITS-1:0]       m_axis_tuser,
  // last_piece
  output logic                                 m_axis_tlast
);
  import tqls_pkg::*;

  localparam int CW = COORD_BITS;

  axis_e  split_axis_q;
  coord_t split_pos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_axis_q <= AXIS_X;
      split_pos_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPLIT_AXIS: split_axis_q <= axis_e'(cfg_wdata_i[0]);
        CFG_SPLIT_POS:  split_pos_q  <= cfg_wdata_i;
      endcase
    end
  end

  quad_t   in_quad;
  logic    ip_valid, pc_ready;
  interp_t ip_res;

  always_comb begin
    in_quad.left       = s_axis_tdata[0*CW +: CW];
    in_quad.top        = s_axis_tdata[1*CW +: CW];
    in_quad.right      = s_axis_tdata[2*CW +: CW];
    in_quad.bottom     = s_axis_tdata[3*CW +: CW];
    in_quad.tex_left   = s_axis_tdata[4*CW +: CW];
    in_quad.tex_top    = s_axis_tdata[5*CW +: CW];
    in_quad.tex_right  = s_axis_tdata[6*CW +: CW];
    in_quad.tex_bottom = s_axis_tdata[7*CW +: CW];
    in_quad.kind       = s_axis_tuser;
  end

  tqls_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .axis_i      (split_axis_q),
    .pos_i       (split_pos_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_quad_i   (in_quad),
    .out_valid_o (ip_valid),
    .out_ready_i (pc_ready),
    .out_res_o   (ip_res)
  );

  // piece stage: hold one quad, emit one or two pieces
  logic    pc_valid_q, pc_second_q, pc_last;
  interp_t pc_res_q;
  quad_t   piece;

  assign pc_last  = !pc_res_q.split || pc_second_q;
  assign pc_ready = !pc_valid_q || (m_axis_tready && pc_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_valid_q  <= 1'b0;
      pc_second_q <= 1'b0;
    end else if (pc_ready) begin
      pc_valid_q  <= ip_valid;
      pc_second_q <= 1'b0;
    end else if (m_axis_tready) begin
      pc_second_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pc_ready) begin
      pc_res_q <= ip_res;
    end
  end

  always_comb begin
    piece = pc_res_q.quad;
    if (pc_res_q.split) begin
      if (!pc_second_q) begin
        if (split_axis_q == AXIS_Y) begin
          piece.bottom     = split_pos_q;
          piece.tex_bottom = pc_res_q.tex_line;
        end else begin
          piece.right     = split_pos_q;
          piece.tex_right = pc_res_q.tex_line;
        end
      end else begin
        if (split_axis_q == AXIS_Y) begin
          piece.top     = split_pos_q;
          piece.tex_top = pc_res_q.tex_line;
        end else begin
          piece.left     = split_pos_q;
          piece.tex_left = pc_res_q.tex_line;
        end
      end
    end
  end

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[0*CW +: CW]  = piece.left;
    m_axis_tdata[1*CW +: CW]  = piece.top;
    m_axis_tdata[2*CW +: CW]  = piece.right;
    m_axis_tdata[3*CW +: CW]  = piece.bottom;
    m_axis_tdata[4*CW +: CW]  = piece.tex_left;
    m_axis_tdata[5*CW +: CW]  = piece.tex_top;
    m_axis_tdata[6*CW +: CW]  = piece.tex_right;
    m_axis_tdata[7*CW +: CW]  = piece.tex_bottom;
  end

  assign m_axis_tvalid = pc_valid_q;
  assign m_axis_tuser  = piece.kind;
  assign m_axis_tlast  = pc_last;

endmodule

`default_nettype wire
